>>> design/rv32m_pkg.sv
// Package with types, codes and the cell stage record shared by the multiply/divide unit.
`default_nettype none
package rv32m_pkg;
  localparam int XLEN = 32;
  localparam int MulStages = 4;
  localparam int BitsPerStage = XLEN / MulStages;
  localparam logic [6:0] LegalFunct7 = 7'b0000001;

  typedef enum logic [2:0] {
    OP_MUL    = 3'b000,
    OP_MULH   = 3'b001,
    OP_MULHSU = 3'b010,
    OP_MULHU  = 3'b011,
    OP_DIV    = 3'b100,
    OP_DIVU   = 3'b101,
    OP_REM    = 3'b110,
    OP_REMU   = 3'b111
  } op_t;

  // Control riding along with each item through the chain.
  typedef struct packed {
    logic    valid;
    op_t     op;
    logic    illegal;
    logic    is_div;
    logic    neg_res;
    logic    div_zero;
    logic [XLEN-1:0] dividend;
  } ctl_t;

  // Data held by one cell: mul uses acc/mcand/mplier, div uses rem/quo/divisor.
  typedef struct packed {
    logic [2*XLEN-1:0] acc;
    logic [2*XLEN-1:0] mcand;
    logic [XLEN-1:0]   mplier;
    logic [XLEN:0]     rem;
    logic [XLEN-1:0]   quo;
    logic [XLEN-1:0]   divisor;
  } dat_t;
endpackage
`default_nettype wire

>>> design/rv32m_cell.sv
// One chain cell: one partial-product slice or one divide step per enabled cycle.
`default_nettype none
module rv32m_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire rv32m_pkg::ctl_t ctl_in,
  input  wire rv32m_pkg::dat_t dat_in,
  output rv32m_pkg::ctl_t      ctl_out,
  output rv32m_pkg::dat_t      dat_out
);
  rv32m_pkg::dat_t dat_next;
  logic [rv32m_pkg::XLEN:0]   shifted;
  logic [rv32m_pkg::XLEN:0]   diff;
  logic [2*rv32m_pkg::XLEN-1:0] part;

  always_comb begin
    dat_next = dat_in;
    // Multiply: BitsPerStage multiplier bits times the full multiplicand.
    part = dat_in.mcand *
           {{(2*rv32m_pkg::XLEN-rv32m_pkg::BitsPerStage){1'b0}},
            dat_in.mplier[rv32m_pkg::BitsPerStage-1:0]};
    // Divide: one restoring step, quotient bit shifted in at the bottom.
    shifted = {dat_in.rem[rv32m_pkg::XLEN-1:0], dat_in.quo[rv32m_pkg::XLEN-1]};
    diff    = shifted - {1'b0, dat_in.divisor};
    if (ctl_in.is_div) begin
      if (!diff[rv32m_pkg::XLEN]) begin
        dat_next.rem = diff;
        dat_next.quo = {dat_in.quo[rv32m_pkg::XLEN-2:0], 1'b1};
      end else begin
        dat_next.rem = shifted;
        dat_next.quo = {dat_in.quo[rv32m_pkg::XLEN-2:0], 1'b0};
      end
    end else begin
      dat_next.acc    = dat_in.acc + part;
      dat_next.mcand  = dat_in.mcand << rv32m_pkg::BitsPerStage;
      dat_next.mplier = dat_in.mplier >> rv32m_pkg::BitsPerStage;
    end
  end

  // Only the valid bit is reset; the payload simply follows it when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.op       <= ctl_in.op;
      ctl_out.illegal  <= ctl_in.illegal;
      ctl_out.is_div   <= ctl_in.is_div;
      ctl_out.neg_res  <= ctl_in.neg_res;
      ctl_out.div_zero <= ctl_in.div_zero;
      ctl_out.dividend <= ctl_in.dividend;
      dat_out          <= dat_next;
    end
  end
endmodule
`default_nettype wire

>>> design/rv32m_multiply_divide_unit.sv
// Top level of the RV32M multiply/divide unit built as a chain of step cells.
// Path: the entry register loads at the input edge, then one cell per quotient bit
// (32 cells) and one output register follow.
// Throughput: one beat per cycle; every item walks the same cell chain, so each
// cell holds a different item and the chain advances whenever the output can move.
// Reset: synchronous and active high; it clears only the valid bits of the chain.
`default_nettype none
module rv32m_multiply_divide_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: [2:0] operation, [9:3] function_group, [41:10] operand_a,
  // [73:42] operand_b, [79:74] zero
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: [31:0] result
  output logic [31:0]      m_tdata,
  // m_tuser: [0] illegal
  output logic             m_tuser
);
  localparam int N = rv32m_pkg::XLEN;

  rv32m_pkg::ctl_t ctl [0:N];
  rv32m_pkg::dat_t dat [0:N];
  logic adv;
  logic [2:0]   in_op;
  logic [6:0]   in_f7;
  logic [N-1:0] a, b, ma, mb;
  logic sa, sb;
  rv32m_pkg::ctl_t ctl0_next;
  rv32m_pkg::dat_t dat0_next;

  // The whole chain moves together; it stalls only when the output register
  // holds a beat that the consumer has not taken.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  assign in_op = s_tdata[2:0];
  assign in_f7 = s_tdata[9:3];
  assign a     = s_tdata[10 +: N];
  assign b     = s_tdata[42 +: N];

  // Entry stage: signs are stripped so the chain works on magnitudes only.
  always_comb begin
    sa = 1'b0;
    sb = 1'b0;
    unique case (rv32m_pkg::op_t'(in_op))
      rv32m_pkg::OP_MULH, rv32m_pkg::OP_DIV, rv32m_pkg::OP_REM: begin
        sa = a[N-1];
        sb = b[N-1];
      end
      rv32m_pkg::OP_MULHSU: sa = a[N-1];
      default: ;
    endcase
    ma = sa ? (~a + 1'b1) : a;
    mb = sb ? (~b + 1'b1) : b;
    ctl0_next.valid    = s_tvalid;
    ctl0_next.op       = rv32m_pkg::op_t'(in_op);
    ctl0_next.illegal  = (in_f7 != rv32m_pkg::LegalFunct7);
    ctl0_next.is_div   = in_op[2];
    ctl0_next.div_zero = (b == '0);
    ctl0_next.dividend = a;
    unique case (rv32m_pkg::op_t'(in_op))
      rv32m_pkg::OP_REM: ctl0_next.neg_res = sa;
      default:           ctl0_next.neg_res = sa ^ sb;
    endcase
    dat0_next.acc     = '0;
    dat0_next.mcand   = {{N{1'b0}}, ma};
    dat0_next.mplier  = mb;
    dat0_next.rem     = '0;
    dat0_next.quo     = ma;
    dat0_next.divisor = mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else if (adv) begin
      ctl[0].valid <= ctl0_next.valid;
    end
    if (adv) begin
      ctl[0].op       <= ctl0_next.op;
      ctl[0].illegal  <= ctl0_next.illegal;
      ctl[0].is_div   <= ctl0_next.is_div;
      ctl[0].neg_res  <= ctl0_next.neg_res;
      ctl[0].div_zero <= ctl0_next.div_zero;
      ctl[0].dividend <= ctl0_next.dividend;
      dat[0]          <= dat0_next;
    end
  end

  // Multiply needs only MulStages cells; later cells pass the product along
  // because the multiplier has been shifted to zero.
  for (genvar i = 0; i < N; i++) begin : g_cell
    rv32m_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .ctl_in  (ctl[i]),
      .dat_in  (dat[i]),
      .ctl_out (ctl[i+1]),
      .dat_out (dat[i+1])
    );
  end

  // Result formatting: sign fix-up, division by zero and illegal codes.
  rv32m_pkg::ctl_t  c;
  rv32m_pkg::dat_t  d;
  logic [2*N-1:0]   prod;
  logic [N-1:0]     res_next;
  assign c = ctl[N];
  assign d = dat[N];

  always_comb begin
    prod = c.neg_res ? (~d.acc + 1'b1) : d.acc;
    unique case (c.op)
      rv32m_pkg::OP_MUL:    res_next = d.acc[N-1:0];
      rv32m_pkg::OP_MULH,
      rv32m_pkg::OP_MULHSU: res_next = prod[2*N-1:N];
      rv32m_pkg::OP_MULHU:  res_next = d.acc[2*N-1:N];
      rv32m_pkg::OP_DIV:    res_next = c.div_zero ? '1 :
                                       (c.neg_res ? (~d.quo + 1'b1) : d.quo);
      rv32m_pkg::OP_DIVU:   res_next = c.div_zero ? '1 : d.quo;
      rv32m_pkg::OP_REM:    res_next = c.div_zero ? c.dividend :
                                       (c.neg_res ? (~d.rem[N-1:0] + 1'b1) : d.rem[N-1:0]);
      default:              res_next = c.div_zero ? c.dividend : d.rem[N-1:0];
    endcase
    if (c.illegal) res_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= res_next;
      m_tuser <= c.illegal;
    end
  end

  // A stalled output beat must keep its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // Illegal beats always carry a zero result.
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("illegal beat with nonzero result");

  // The chain advances in lockstep with the input handshake.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with chain advance");
endmodule
`default_nettype wire

>>> tb/rv32m_md_checker.sv
// Checker that predicts and compares every result beat of the multiply/divide unit.
module rv32m_md_checker
  import rv32m_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  typedef struct packed {
    logic [31:0] value;
    logic        illegal;
  } md_result_t;

  md_result_t expected_q[$];

  // Computes the instruction result from the architectural definition.
  function automatic md_result_t predict_md(op_t op, logic [6:0] f7, logic [31:0] a,
                                            logic [31:0] b);
    md_result_t r;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] prod;
    logic [63:0] uprod;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] q;
    logic [31:0] rm;
    r.illegal = 1'b0;
    r.value = '0;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    if (f7 != LegalFunct7) begin
      r.illegal = 1'b1;
      return r;
    end
    case (op)
      OP_MUL: r.value = a * b;
      OP_MULH: begin
        prod = sa * sb;
        r.value = prod[63:32];
      end
      OP_MULHSU: begin
        prod = sa * $signed({32'd0, b});
        r.value = prod[63:32];
      end
      OP_MULHU: begin
        uprod = {32'd0, a} * {32'd0, b};
        r.value = uprod[63:32];
      end
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          r.value = (op == OP_DIV) ? 32'hFFFF_FFFF : a;
        end else begin
          q = mag_a / mag_b;
          rm = mag_a % mag_b;
          if (op == OP_DIV) r.value = (a[31] != b[31]) ? -q : q;
          else r.value = a[31] ? -rm : rm;
        end
      end
      OP_DIVU: r.value = (b == 0) ? 32'hFFFF_FFFF : a / b;
      default: r.value = (b == 0) ? a : a % b;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  assign pending = expected_q.size();

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    md_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.value) report_mismatch("result", m_tdata, want.value);
          if (m_tuser !== want.illegal) report_mismatch("illegal", m_tuser, want.illegal);
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(predict_md(op_t'(s_tdata[2:0]), s_tdata[9:3],
                                        s_tdata[41:10], s_tdata[73:42]));
    end
  end
endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, stimulus, idling and the final verdict.
module testbench;
  import rv32m_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          beats_sent = 0;

  localparam int CycleLimit = 200000;
  localparam int Latency = XLEN + 2;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rv32m_multiply_divide_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rv32m_md_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // The receiver stalls at random on the falling edge, at the current idle rate.
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // A runaway guard: the slowest correct run is far below this bound.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Operands biased toward the corners, where signed and overflow cases live.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Sends one beat; tvalid stays high from one beat to the next with no idle,
  // and drops only when the sender decides to idle.
  task automatic send_beat(op_t op, logic [6:0] f7, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, b, a, f7, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_random(int count);
    op_t op;
    logic [6:0] f7;
    for (int i = 0; i < count; i++) begin
      op = op_t'($urandom_range(7));
      // Most instructions are legal; the rest use a random funct7 code.
      f7 = ($urandom_range(9) < 8) ? LegalFunct7 : 7'($urandom_range(127));
      send_beat(op, f7, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    op_t op;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: every operation over the operand corners, division by
    // zero, the signed overflow case and illegal funct7 codes.
    send_idle_pct = 38;
    recv_idle_pct = 46;
    for (int k = 0; k < 8; k++) begin
      op = op_t'(k);
      send_beat(op, LegalFunct7, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(op, LegalFunct7, 32'hFFFF_FFFF, 32'd0);
    end
    send_beat(OP_MULH, LegalFunct7, 32'h8000_0000, 32'h8000_0000);
    send_beat(OP_MULHSU, LegalFunct7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_MULHU, LegalFunct7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_DIV, LegalFunct7, 32'h7FFF_FFFF, 32'h0000_0002);
    send_beat(OP_DIV, 7'd0, 32'h1234_5678, 32'h9ABC_DEF0);
    send_beat(OP_REMU, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_MUL, 7'h7E, 32'd0, 32'd0);

    // Random part in three idling phases.
    send_random(260);
    send_idle_pct = 46;
    recv_idle_pct = 38;
    send_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(260);
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);

    $display("Sent %0d instruction beats covering all eight operations and illegal codes,",
             beats_sent);
    $display("checked %0d result beats under three idling patterns.", results_seen);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

>>> files.f
design/rv32m_pkg.sv
design/rv32m_cell.sv
design/rv32m_multiply_divide_unit.sv
tb/rv32m_md_checker.sv
tb/testbench.sv
